>>> hdl/rlw_pkg.sv
`default_nettype none
package rlw_pkg;

  // Field widths
  localparam int TIME_W      = 48;
  localparam int SEQ_W       = 16;
  localparam int BYTES_W     = 16;
  localparam int LOSS_VAL_W  = 15;
  localparam int WIN_W       = 24;
  localparam int EXP_OUT_W   = 25;
  localparam int BYTES_OUT_W = 26;
  localparam int PKTS_OUT_W  = 11;
  localparam int SPAN_W      = 24;

  // Window length after reset, in microseconds
  localparam logic [WIN_W-1:0] WINDOW_RESET = 24'd2000000;

  // Packed FIFO entry widths
  localparam int LOSS_ENTRY_W = TIME_W + 2 * LOSS_VAL_W;
  localparam int BYTE_ENTRY_W = TIME_W + BYTES_W;

  // Per-request sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOSS_RD,
    ST_LOSS_CHK,
    ST_BYTE_RD,
    ST_BYTE_CHK,
    ST_SPAN_RD,
    ST_DONE
  } state_t;

  // Shared time unit result
  typedef struct packed {
    logic              expired;
    logic [SPAN_W-1:0] span;
  } time_res_t;

endpackage
`default_nettype wire

>>> hdl/rtp_sequence_loss_window.sv
// RTP receive loss / byte statistics over a sliding time window.
// Input channel (in_valid/in_ready): one request per received packet with
// arrival_time_us, sequence_req and packet_bytes. Output channel
// (out_valid/out_ready): one result per request with the window sums for
// expected, lost and bytes, the byte-sample count, the span from the oldest
// byte sample, and an overflow flag when a full FIFO dropped its oldest entry.
// cfg_wr_en/cfg_wr_data write window_length_us; write only while idle.
// Sequence: an accepted request steps through LOSS_RD, LOSS_CHK, BYTE_CHK,
// SPAN_RD and DONE to the result register; every expired entry trimmed
// from either FIFO adds one FIFO read and one compare in the shared time
// unit (a RD and a CHK state) before the walk goes on. in_ready is high
// only in the idle state; the next request can be accepted while a result
// still waits in the output register. If the receiver stalls with a result
// pending, the sequencer holds the following result until the register frees.
// Reset: last sequence cleared, both FIFOs empty, sums zero, window 2000000 us.
// FIFO storage is not cleared; entries are only read after being written.
`default_nettype none
module rtp_sequence_loss_window #(
  parameter int FIFO_DEPTH = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [rlw_pkg::WIN_W-1:0]       cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [rlw_pkg::TIME_W-1:0]      arrival_time_us,
  input  wire logic [rlw_pkg::SEQ_W-1:0]       sequence_req,
  input  wire logic [rlw_pkg::BYTES_W-1:0]     packet_bytes,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [rlw_pkg::EXP_OUT_W-1:0]        window_expected,
  output logic [rlw_pkg::EXP_OUT_W-1:0]        window_lost,
  output logic [rlw_pkg::BYTES_OUT_W-1:0]      window_bytes,
  output logic [rlw_pkg::PKTS_OUT_W-1:0]       window_packets,
  output logic [rlw_pkg::SPAN_W-1:0]           window_span_us,
  output logic                                 overflow
);
  import rlw_pkg::*;

  localparam int IDX_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int LSUM_W = LOSS_VAL_W + CNT_W;
  localparam int BSUM_W = BYTES_W + CNT_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  state_t state, state_next;

  // Config
  logic [WIN_W-1:0] window;

  // Sequence tracking
  logic [SEQ_W-1:0] last_seq;
  logic             have_last_seq;
  logic [SEQ_W-1:0] seq_diff;
  logic             seq_fwd;

  // Latched request
  logic [TIME_W-1:0]     now;
  logic [BYTES_W-1:0]    bytes_q;
  logic [LOSS_VAL_W-1:0] exp_q;
  logic [LOSS_VAL_W-1:0] lost_q;
  logic                  loss_sample;
  logic                  ovf;

  // FIFO pointers and sums
  logic [IDX_W-1:0]  loss_head, loss_tail, byte_head, byte_tail;
  logic [CNT_W-1:0]  loss_count, byte_count;
  logic [LSUM_W-1:0] sum_expected, sum_lost;
  logic [BSUM_W-1:0] sum_bytes;

  // RAM read data
  logic [LOSS_ENTRY_W-1:0] loss_rdata;
  logic [BYTE_ENTRY_W-1:0] byte_rdata;
  logic [TIME_W-1:0]       loss_rd_time, byte_rd_time;
  logic [LOSS_VAL_W-1:0]   loss_rd_exp, loss_rd_lost;
  logic [BYTES_W-1:0]      byte_rd_bytes;

  // Control
  logic      accept, loss_pop, loss_push, byte_pop, byte_push, out_load;
  logic      loss_pop_exp, byte_pop_exp, loss_full_pop, byte_full_pop;
  time_res_t tres;
  logic [TIME_W-1:0] unit_time;

  assign loss_rd_time  = loss_rdata[LOSS_ENTRY_W-1 -: TIME_W];
  assign loss_rd_exp   = loss_rdata[2*LOSS_VAL_W-1 -: LOSS_VAL_W];
  assign loss_rd_lost  = loss_rdata[LOSS_VAL_W-1:0];
  assign byte_rd_time  = byte_rdata[BYTE_ENTRY_W-1 -: TIME_W];
  assign byte_rd_bytes = byte_rdata[BYTES_W-1:0];

  // Sample memories
  rlw_ram #(.WIDTH(LOSS_ENTRY_W), .DEPTH(FIFO_DEPTH)) u_loss_ram (
    .clk   (clk),
    .we    (loss_push),
    .waddr (loss_tail),
    .wdata ({now, exp_q, lost_q}),
    .raddr (loss_head),
    .rdata (loss_rdata)
  );

  rlw_ram #(.WIDTH(BYTE_ENTRY_W), .DEPTH(FIFO_DEPTH)) u_byte_ram (
    .clk   (clk),
    .we    (byte_push),
    .waddr (byte_tail),
    .wdata ({now, bytes_q}),
    .raddr (byte_head),
    .rdata (byte_rdata)
  );

  // Shared compare / subtract unit
  assign unit_time = (state == ST_LOSS_CHK) ? loss_rd_time : byte_rd_time;

  rlw_time_unit u_time (
    .now        (now),
    .entry_time (unit_time),
    .window     (window),
    .res        (tres)
  );

  // Forward step test on the incoming sequence number
  assign seq_diff = sequence_req - last_seq;
  assign seq_fwd  = (seq_diff != '0) && !seq_diff[SEQ_W-1];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_LOSS_RD;
      ST_LOSS_RD:  state_next = ST_LOSS_CHK;
      ST_LOSS_CHK: state_next = loss_pop_exp ? ST_LOSS_RD : ST_BYTE_CHK;
      ST_BYTE_RD:  state_next = ST_BYTE_CHK;
      ST_BYTE_CHK: state_next = byte_pop_exp ? ST_BYTE_RD : ST_SPAN_RD;
      ST_SPAN_RD:  state_next = ST_DONE;
      ST_DONE:     if (!out_valid || out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    accept        = 1'b0;
    loss_pop_exp  = 1'b0;
    byte_pop_exp  = 1'b0;
    loss_full_pop = 1'b0;
    byte_full_pop = 1'b0;
    loss_push     = 1'b0;
    byte_push     = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: accept = in_valid;
      ST_LOSS_CHK: begin
        loss_pop_exp = (loss_count != '0) && tres.expired;
        if (!loss_pop_exp && loss_sample) begin
          loss_push     = 1'b1;
          loss_full_pop = (loss_count == FULL_CNT);
        end
      end
      ST_BYTE_CHK: begin
        byte_pop_exp = (byte_count != '0) && tres.expired;
        if (!byte_pop_exp) begin
          byte_push     = 1'b1;
          byte_full_pop = (byte_count == FULL_CNT);
        end
      end
      ST_DONE: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign loss_pop = loss_pop_exp | loss_full_pop;
  assign byte_pop = byte_pop_exp | byte_full_pop;
  assign in_ready = (state == ST_IDLE);

  // Sequencer state and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      window <= WINDOW_RESET;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        window <= cfg_wr_data;
      end
    end
  end

  // Request latch and loss sample
  always_ff @(posedge clk) begin
    if (rst) begin
      last_seq      <= '0;
      have_last_seq <= 1'b0;
      loss_sample   <= 1'b0;
      ovf           <= 1'b0;
    end else if (accept) begin
      ovf <= 1'b0;
      if (!have_last_seq) begin
        loss_sample   <= 1'b1;
        last_seq      <= sequence_req;
        have_last_seq <= 1'b1;
      end else begin
        loss_sample <= seq_fwd;
        if (seq_fwd) begin
          last_seq <= sequence_req;
        end
      end
    end else if (loss_full_pop || byte_full_pop) begin
      ovf <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now     <= arrival_time_us;
      bytes_q <= packet_bytes;
      if (!have_last_seq) begin
        exp_q  <= LOSS_VAL_W'(1);
        lost_q <= '0;
      end else begin
        exp_q  <= seq_diff[LOSS_VAL_W-1:0];
        lost_q <= seq_diff[LOSS_VAL_W-1:0] - 1'b1;
      end
    end
  end

  // Loss FIFO pointers and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_head    <= '0;
      loss_tail    <= '0;
      loss_count   <= '0;
      sum_expected <= '0;
      sum_lost     <= '0;
    end else begin
      if (loss_pop)  loss_head <= ptr_inc(loss_head);
      if (loss_push) loss_tail <= ptr_inc(loss_tail);
      if (loss_pop && !loss_push) begin
        loss_count <= loss_count - 1'b1;
      end else if (loss_push && !loss_pop) begin
        loss_count <= loss_count + 1'b1;
      end
      sum_expected <= sum_expected
                    - (loss_pop  ? LSUM_W'(loss_rd_exp)  : '0)
                    + (loss_push ? LSUM_W'(exp_q)        : '0);
      sum_lost     <= sum_lost
                    - (loss_pop  ? LSUM_W'(loss_rd_lost) : '0)
                    + (loss_push ? LSUM_W'(lost_q)       : '0);
    end
  end

  // Byte FIFO pointers and sum
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_head  <= '0;
      byte_tail  <= '0;
      byte_count <= '0;
      sum_bytes  <= '0;
    end else begin
      if (byte_pop)  byte_head <= ptr_inc(byte_head);
      if (byte_push) byte_tail <= ptr_inc(byte_tail);
      if (byte_pop && !byte_push) begin
        byte_count <= byte_count - 1'b1;
      end else if (byte_push && !byte_pop) begin
        byte_count <= byte_count + 1'b1;
      end
      sum_bytes <= sum_bytes
                 - (byte_pop  ? BSUM_W'(byte_rd_bytes) : '0)
                 + (byte_push ? BSUM_W'(bytes_q)       : '0);
    end
  end

  // Output register handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload with saturation to field widths
  always_ff @(posedge clk) begin
    if (out_load) begin
      window_expected <= ({{(64-LSUM_W){1'b0}}, sum_expected} > 64'h1FF_FFFF)
                       ? '1 : EXP_OUT_W'(sum_expected);
      window_lost     <= ({{(64-LSUM_W){1'b0}}, sum_lost} > 64'h1FF_FFFF)
                       ? '1 : EXP_OUT_W'(sum_lost);
      window_bytes    <= ({{(64-BSUM_W){1'b0}}, sum_bytes} > 64'h3FF_FFFF)
                       ? '1 : BYTES_OUT_W'(sum_bytes);
      window_packets  <= ({{(64-CNT_W){1'b0}}, byte_count} > 64'h7FF)
                       ? '1 : PKTS_OUT_W'(byte_count);
      window_span_us  <= tres.span;
      overflow        <= ovf;
    end
  end

  // Checks
  a_loss_count_bound: assert property (@(posedge clk) disable iff (rst)
    loss_count <= FULL_CNT)
    else $error("loss FIFO count above depth");

  a_byte_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= FULL_CNT)
    else $error("byte FIFO count above depth");

  a_loss_empty_sums: assert property (@(posedge clk) disable iff (rst)
    loss_count == '0 |-> sum_expected == '0 && sum_lost == '0)
    else $error("loss sums nonzero with empty FIFO");

  a_byte_empty_sum: assert property (@(posedge clk) disable iff (rst)
    byte_count == '0 |-> sum_bytes == '0)
    else $error("byte sum nonzero with empty FIFO");

  a_done_has_sample: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> byte_count != '0)
    else $error("result without a byte sample");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request taken while previous one in progress");

endmodule
`default_nettype wire

>>> hdl/rlw_ram.sv
`default_nettype none
module rlw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/rlw_time_unit.sv
`default_nettype none
module rlw_time_unit (
  input  wire logic [rlw_pkg::TIME_W-1:0] now,
  input  wire logic [rlw_pkg::TIME_W-1:0] entry_time,
  input  wire logic [rlw_pkg::WIN_W-1:0]  window,
  output rlw_pkg::time_res_t              res
);
  import rlw_pkg::*;

  logic [TIME_W:0]   diff;
  logic              ahead;

  // One subtract serves both the expiry test and the span
  assign diff  = {1'b0, now} - {1'b0, entry_time};
  assign ahead = !diff[TIME_W] && (diff != '0);

  always_comb begin
    // now - t > window  <=>  t + window < now
    res.expired = ahead && (diff[TIME_W-1:0] > {{(TIME_W-WIN_W){1'b0}}, window});
    // Span clamps at zero for time going backward and saturates at 24 bits
    if (!ahead) begin
      res.span = '0;
    end else if (diff[TIME_W-1:SPAN_W] != '0) begin
      res.span = '1;
    end else begin
      res.span = diff[SPAN_W-1:0];
    end
  end

endmodule
`default_nettype wire
